### rtl/row_centered_moving_average_assert.svh
// assertion macros
`ifndef ROW_CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define ROW_CENTERED_MOVING_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCMA_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("rcma assertion failed");
`define RCMA_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("rcma assertion failed");
`else
`define RCMA_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define RCMA_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/rcma_pkg.sv
package rcma_pkg;
	localparam int MAX_COLS_DEF = 64;
	localparam int IDX_MAX_W = 10;
	localparam int WS_W = 7;
	localparam logic [WS_W-1:0] WS_RESET = 7'd8;

	typedef struct packed {
		logic [IDX_MAX_W-1:0] first;
		logic [IDX_MAX_W-1:0] last;
		logic                 last_out;
		logic                 err;
	} cmd_t;

	typedef struct packed {
		logic                 en;
		logic [IDX_MAX_W-1:0] addr;
		logic signed [15:0]   data;
	} wr_t;

	typedef enum logic [1:0] {F_ACCEPT, F_ISSUE, F_WAIT} front_st_t;
	typedef enum logic [2:0] {B_IDLE, B_READ, B_PREP, B_DIV, B_OUT} back_st_t;
endpackage

### rtl/rcma_fifo.sv
module rcma_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcma_pkg::cmd_t    push_data,
	input  logic              pop,
	output rcma_pkg::cmd_t    pop_data,
	output logic              full,
	output logic              empty
);
	rcma_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule

### rtl/rcma_front.sv
`include "row_centered_moving_average_assert.svh"
module rcma_front #(
	parameter int MAX_COLS = rcma_pkg::MAX_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [rcma_pkg::WS_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [15:0]       sample,
	input  logic                     last_in_row,
	output rcma_pkg::wr_t            wr,
	output logic                     push,
	output rcma_pkg::cmd_t           cmd,
	input  logic                     q_full,
	input  logic                     q_empty,
	input  logic                     back_busy
);
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int EXT_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

	rcma_pkg::front_st_t st_q, st_d;
	logic [rcma_pkg::WS_W-1:0] ws_q;
	logic [CNT_W-1:0] len_q, j_q, n_q;
	logic [5:0] half_q;
	logic err_q;
	logic acc, room;
	logic [CNT_W-1:0] n_new;
	logic [EXT_W-1:0] jx, hx, nx, first_x, last_x;

	assign room = len_q < CNT_W'(MAX_COLS);
	assign acc = in_valid && in_ready;
	assign n_new = room ? len_q + CNT_W'(1) : len_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		st_d = st_q;
		case (st_q)
			rcma_pkg::F_ACCEPT: if (acc && last_in_row) st_d = rcma_pkg::F_ISSUE;
			rcma_pkg::F_ISSUE:  if (push && j_q == n_q - CNT_W'(1)) st_d = rcma_pkg::F_WAIT;
			rcma_pkg::F_WAIT:   if (q_empty && !back_busy) st_d = rcma_pkg::F_ACCEPT;
			default:            st_d = rcma_pkg::F_ACCEPT;
		endcase
	end

	always_comb begin
		jx = EXT_W'(j_q);
		hx = EXT_W'(half_q);
		nx = EXT_W'(n_q);
		first_x = (jx >= hx) ? jx - hx : '0;
		last_x = (jx + hx >= nx) ? nx - EXT_W'(1) : jx + hx;
		in_ready = st_q == rcma_pkg::F_ACCEPT;
		push = (st_q == rcma_pkg::F_ISSUE) && !q_full;
		cmd.first = rcma_pkg::IDX_MAX_W'(first_x);
		cmd.last = rcma_pkg::IDX_MAX_W'(last_x);
		cmd.last_out = j_q == n_q - CNT_W'(1);
		cmd.err = err_q;
		wr.en = acc && room;
		wr.addr = rcma_pkg::IDX_MAX_W'(len_q);
		wr.data = sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rcma_pkg::F_ACCEPT;
			ws_q <= rcma_pkg::WS_RESET;
			len_q <= '0;
			j_q <= '0;
			n_q <= '0;
			half_q <= '0;
			err_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid) ws_q <= cfg_data;
			if (acc) begin
				if (last_in_row) begin
					len_q <= '0;
					n_q <= n_new;
					j_q <= '0;
					half_q <= ws_q[6:1];
					err_q <= ws_q == '0;
				end else begin
					len_q <= n_new;
				end
			end
			if (push) j_q <= j_q + CNT_W'(1);
		end
	end

	`RCMA_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, q_empty && !back_busy)
	`RCMA_ASSERT_IMP(a_push_room, clk, arst_n, push, !q_full)
	`RCMA_ASSERT_IMP(a_issue_range, clk, arst_n, st_q == rcma_pkg::F_ISSUE, j_q < n_q)
endmodule

### rtl/rcma_back.sv
module rcma_back #(
	parameter int MAX_COLS = rcma_pkg::MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rcma_pkg::wr_t      wr,
	input  rcma_pkg::cmd_t     cmd,
	input  logic               q_empty,
	output logic               pop,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] smoothed,
	output logic               last_out,
	output logic               window_error
);
	localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int SUM_W = 16 + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic signed [15:0] mem [MAX_COLS];
	rcma_pkg::back_st_t st_q, st_d;
	logic [IDX_W-1:0] addr_q, lastidx_q;
	logic issuing_q, pend_q, lo_q, err_q, neg_q;
	logic signed [15:0] rd_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W:0] rem_q, trial;
	logic [CNT_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic load_out, qbit;
	logic [SUM_W-1:0] quo_s;
	logic out_valid_q, lo_out_q, err_out_q;
	logic signed [15:0] sm_q;

	assign trial = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
	assign qbit = trial >= {1'b0, den_q};
	assign quo_s = neg_q ? -dvd_q : dvd_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			rcma_pkg::B_IDLE: if (!q_empty) st_d = rcma_pkg::B_READ;
			rcma_pkg::B_READ: if (!issuing_q && pend_q) st_d = rcma_pkg::B_PREP;
			rcma_pkg::B_PREP: st_d = rcma_pkg::B_DIV;
			rcma_pkg::B_DIV:  if (step_q == STEP_W'(SUM_W - 1)) st_d = rcma_pkg::B_OUT;
			rcma_pkg::B_OUT:  if (!out_valid_q || out_ready) st_d = rcma_pkg::B_IDLE;
			default:          st_d = rcma_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = (st_q == rcma_pkg::B_IDLE) && !q_empty;
		busy = st_q != rcma_pkg::B_IDLE;
		load_out = (st_q == rcma_pkg::B_OUT) && (!out_valid_q || out_ready);
		out_valid = out_valid_q;
		smoothed = sm_q;
		last_out = lo_out_q;
		window_error = err_out_q;
	end

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr[IDX_W-1:0]] <= wr.data;
		if (issuing_q) rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rcma_pkg::B_IDLE;
			issuing_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				issuing_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (st_q == rcma_pkg::B_READ) begin
				pend_q <= issuing_q;
				if (issuing_q && addr_q == lastidx_q) issuing_q <= 1'b0;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q <= cmd.first[IDX_W-1:0];
			lastidx_q <= cmd.last[IDX_W-1:0];
			den_q <= CNT_W'(cmd.last - cmd.first) + CNT_W'(1);
			lo_q <= cmd.last_out;
			err_q <= cmd.err;
			sum_q <= '0;
		end else if (st_q == rcma_pkg::B_READ) begin
			if (issuing_q && addr_q != lastidx_q) addr_q <= addr_q + IDX_W'(1);
			if (pend_q) sum_q <= sum_q + SUM_W'(rd_q);
		end
		if (st_q == rcma_pkg::B_PREP) begin
			neg_q <= sum_q[SUM_W-1];
			dvd_q <= sum_q[SUM_W-1] ? -sum_q : sum_q;
			rem_q <= '0;
			step_q <= '0;
		end
		if (st_q == rcma_pkg::B_DIV) begin
			rem_q <= qbit ? trial - {1'b0, den_q} : trial;
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
			step_q <= step_q + STEP_W'(1);
		end
		if (load_out) begin
			sm_q <= quo_s[15:0];
			lo_out_q <= lo_q;
			err_out_q <= err_q;
		end
	end
endmodule

### rtl/row_centered_moving_average.sv
// Samples are taken one per cycle while a row is collected. For each result of a row, the
// window is summed serially from the row memory (B_READ), then divided by the restoring
// divider (B_PREP, B_DIV) and registered for output (B_OUT).
// The next row is accepted once the last result of a row has left the divider.
// arst_n clears control state asynchronously; the window length register resets to 8.
module row_centered_moving_average #(
	parameter int MAX_COLS = rcma_pkg::MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               last_in_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] smoothed,
	output logic               last_out,
	output logic               window_error
);
	rcma_pkg::wr_t wr;
	rcma_pkg::cmd_t cmd_in, cmd_out;
	logic push, pop, q_full, q_empty, back_busy;

	rcma_front #(.MAX_COLS(MAX_COLS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.last_in_row(last_in_row), .wr(wr), .push(push), .cmd(cmd_in),
		.q_full(q_full), .q_empty(q_empty), .back_busy(back_busy)
	);

	rcma_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(cmd_in),
		.pop(pop), .pop_data(cmd_out), .full(q_full), .empty(q_empty)
	);

	rcma_back #(.MAX_COLS(MAX_COLS)) u_back (
		.clk(clk), .arst_n(arst_n), .wr(wr), .cmd(cmd_out), .q_empty(q_empty),
		.pop(pop), .busy(back_busy), .out_valid(out_valid), .out_ready(out_ready),
		.smoothed(smoothed), .last_out(last_out), .window_error(window_error)
	);
endmodule
